### design/lie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line input editor package
// Character codes and the result kinds shared by the line editor.
// ----------------------------------------------------------------------------
package lie_pkg;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_NUL = 8'h00;

   localparam logic REQ_TYPED = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [8:0] CAP_RESET = 9'd80;

   typedef enum logic [1:0] {
      KIND_READ,
      KIND_ECHO,
      KIND_NEWLINE,
      KIND_ERASE
   } kind_type;

   localparam logic [1:0] STEP_FIRST = 2'd0;
   localparam logic [1:0] STEP_SPACE = 2'd1;
   localparam logic [1:0] STEP_FINAL = 2'd2;

endpackage

### design/line_input_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line input editor
// Keeps a typed line in a buffer memory, echoes edits and answers reads.
// ----------------------------------------------------------------------------
// Typed characters and read requests arrive as items on the req channel; tuser
// selects a typed character (0) or a read (1). Each item gives zero to three
// result items on the rsp channel, the final one marked by tlast. A carriage
// return stores a terminator, echoes a newline with line_done and the line
// length, and empties the line. A backspace on a non-empty line echoes
// backspace, space, backspace. Printable characters are stored and echoed while
// room remains. csr_data sets the line capacity, to be written only while idle;
// the block does not enforce this. An item is registered in stage one, with the
// synchronous buffer read, then in the output register. An item that gives one
// result can be accepted every cycle unless rsp stalls; an erase holds the
// output register for its three results. The buffer has one write and one read
// port, and a write at acceptance is seen by a read accepted in the next cycle.
// Reset empties the line, clears the pipeline and sets the capacity to 80; the
// buffer contents are left as they are. While the receiver stalls, the output
// register and one decoded item are held and req_tready falls.
// ----------------------------------------------------------------------------
module line_input_editor #(
   parameter int BUF_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // in_char [7:0], read_index [15:8]
   input  logic        req_tuser,   // req_type [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_char [7:0], line_length [15:8]
   output logic [1:0]  rsp_tuser,   // is_read_data [0], line_done [1]
   output logic        rsp_tlast
);
   import lie_pkg::*;

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CapMaxInt = (BUF_DEPTH < 256) ? BUF_DEPTH : 256;
   localparam logic [8:0] CAP_MAX = 9'(CapMaxInt);

   logic [7:0]    line_store_ff [BUF_DEPTH];
   logic [7:0]    rd_data_ff;

   logic [8:0]    cap_ff, cap_in;
   logic [7:0]    wr_idx_ff, wr_idx_in;

   logic          s1_valid_ff, s1_valid_in;
   kind_type      s1_kind_ff;
   logic [7:0]    s1_char_ff;
   logic [7:0]    s1_len_ff;
   logic          s1_rd_ok_ff;

   logic          e_valid_ff, e_valid_in;
   kind_type      e_kind_ff;
   logic [7:0]    e_char_ff;
   logic [7:0]    e_len_ff;
   logic [1:0]    e_step_ff, e_step_in;

   logic [7:0]    in_char;
   logic [7:0]    read_index;
   logic [8:0]    cap_eff;
   logic [8:0]    idx_ext;
   logic          typed_ok;
   logic          has_result;
   kind_type      dec_kind;
   logic [7:0]    dec_len;
   logic          mem_we;
   logic [7:0]    mem_wdata;
   logic [7:0]    wr_idx_next;
   logic          rd_ok;
   logic          is_cr_ok;

   logic          req_fire, rsp_fire, e_done, e_free, s1_move;

   assign in_char    = req_tdata[7:0];
   assign read_index = req_tdata[15:8];

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign e_done     = rsp_fire && rsp_tlast;
   assign e_free     = !e_valid_ff || e_done;
   assign s1_move    = s1_valid_ff && e_free;
   assign req_tready = !s1_valid_ff || e_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      cap_eff     = (cap_ff > CAP_MAX) ? CAP_MAX : cap_ff;
      idx_ext     = {1'b0, wr_idx_ff};
      typed_ok    = (cap_eff != 9'd0) && (idx_ext < cap_eff);
      rd_ok       = 32'(read_index) < BUF_DEPTH;
      has_result  = 1'b0;
      dec_kind    = KIND_ECHO;
      dec_len     = 8'd0;
      mem_we      = 1'b0;
      mem_wdata   = in_char;
      wr_idx_next = wr_idx_ff;
      is_cr_ok    = 1'b0;
      if (req_tuser == REQ_READ) begin
         has_result = 1'b1;
         dec_kind   = KIND_READ;
      end else if (typed_ok) begin
         if (in_char == CH_CR) begin
            has_result  = 1'b1;
            is_cr_ok    = 1'b1;
            dec_kind    = KIND_NEWLINE;
            dec_len     = wr_idx_ff;
            mem_we      = 1'b1;
            mem_wdata   = CH_NUL;
            wr_idx_next = 8'd0;
         end else if (in_char == CH_BS) begin
            if (wr_idx_ff != 8'd0) begin
               has_result  = 1'b1;
               dec_kind    = KIND_ERASE;
               wr_idx_next = wr_idx_ff - 8'd1;
            end
         end else if (in_char >= CH_SP && (idx_ext + 9'd1) < cap_eff) begin
            has_result  = 1'b1;
            dec_kind    = KIND_ECHO;
            mem_we      = 1'b1;
            wr_idx_next = wr_idx_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && mem_we) begin
         line_store_ff[AW'(wr_idx_ff)] <= mem_wdata;
      end
      if (req_fire && req_tuser == REQ_READ) begin
         rd_data_ff <= line_store_ff[AW'(read_index)];
      end
   end

   always_comb begin
      cap_in = (csr_valid && csr_ready) ? csr_data : cap_ff;
      wr_idx_in = req_fire ? wr_idx_next : wr_idx_ff;
      if (req_fire) begin
         s1_valid_in = has_result;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         e_valid_in = 1'b1;
         e_step_in  = STEP_FIRST;
      end else if (e_done) begin
         e_valid_in = 1'b0;
         e_step_in  = STEP_FIRST;
      end else if (rsp_fire) begin
         e_valid_in = e_valid_ff;
         e_step_in  = e_step_ff + 2'd1;
      end else begin
         e_valid_in = e_valid_ff;
         e_step_in  = e_step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= CAP_RESET;
         wr_idx_ff   <= 8'd0;
         s1_valid_ff <= 1'b0;
         e_valid_ff  <= 1'b0;
         e_step_ff   <= STEP_FIRST;
      end else begin
         cap_ff      <= cap_in;
         wr_idx_ff   <= wr_idx_in;
         s1_valid_ff <= s1_valid_in;
         e_valid_ff  <= e_valid_in;
         e_step_ff   <= e_step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff  <= dec_kind;
         s1_char_ff  <= in_char;
         s1_len_ff   <= dec_len;
         s1_rd_ok_ff <= rd_ok;
      end
      if (s1_move) begin
         e_kind_ff <= s1_kind_ff;
         e_len_ff  <= s1_len_ff;
         if (s1_kind_ff == KIND_READ) begin
            e_char_ff <= s1_rd_ok_ff ? rd_data_ff : CH_NUL;
         end else begin
            e_char_ff <= s1_char_ff;
         end
      end
   end

   always_comb begin
      rsp_tvalid = e_valid_ff;
      rsp_tlast  = 1'b1;
      rsp_tuser  = 2'b00;
      case (e_kind_ff)
         KIND_READ: begin
            rsp_tdata = {8'd0, e_char_ff};
            rsp_tuser = 2'b01;
         end
         KIND_ECHO: begin
            rsp_tdata = {8'd0, e_char_ff};
         end
         KIND_NEWLINE: begin
            rsp_tdata = {e_len_ff, CH_NL};
            rsp_tuser = 2'b10;
         end
         KIND_ERASE: begin
            rsp_tdata = {8'd0, (e_step_ff == STEP_SPACE) ? CH_SP : CH_BS};
            rsp_tlast = (e_step_ff == STEP_FINAL);
         end
         default: begin
            rsp_tdata = {8'd0, e_char_ff};
         end
      endcase
   end

   a_index_in_buffer: assert property (@(posedge clock) disable iff (reset)
      {1'b0, wr_idx_ff} < CAP_MAX)
      else $error("Write index has left the buffer.");

   a_single_step: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff && e_kind_ff != KIND_ERASE |-> e_step_ff == STEP_FIRST)
      else $error("A single-result item has advanced its step count.");

   a_erase_steps: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff && e_kind_ff == KIND_ERASE |-> e_step_ff != 2'd3)
      else $error("Erase sequence has run past its final step.");

   a_line_closed: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_cr_ok |=> wr_idx_ff == 8'd0)
      else $error("Line not emptied after a carriage return.");

endmodule
